// ===== design/kst_pkg.sv =====
// Package for the keyed set table: operation and status codes, the default
// table capacity and the controller state type. It has no dependencies of its own.
`default_nettype none

package kst_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;
	localparam logic [1:0] MODE_READ   = 2'd3;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FOUND     = 3'd4;
	localparam logic [2:0] ST_READ_OK   = 3'd5;
	localparam logic [2:0] ST_RANGE_ERR = 3'd6;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_RDWAIT = 5'b00100,
		S_MOVE   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

endpackage

`default_nettype wire

// ===== design/keyed_set_table.sv =====
// Keyed set table: a bounded unsorted table of (code, date) keys searched
// linearly through a key memory with one write port and one registered read port. Depends on kst_pkg.
//
// Usage: one request transaction enters on in_valid/in_stall carrying mode,
// product_code, expiry_date and read_index; one result transaction leaves on
// out_valid/out_stall carrying status, found_index, live_count, code_out and
// date_out. in_stall is high from acceptance until the result has been taken,
// so only one request is in the block at a time.
// Add, remove and lookup walk the live entries one per cycle through the
// key memory's registered read port. A remove that hits then copies the last
// live entry into the freed slot. An add to a full table and a read of an
// index out of range answer straight from the idle state without a scan, and
// a read in range returns the entry through the registered read port. The next
// request can be accepted in the cycle after the result is taken.
// Reset empties the table by clearing the live count; the key memory itself
// is not cleared, as only entries below the count are ever read. While the
// receiver holds out_stall the result stays steady and no request is taken.
`default_nettype none

module keyed_set_table
	import kst_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] product_code,
	input  wire logic [31:0] expiry_date,
	input  wire logic [5:0]  read_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [5:0]       found_index,
	output logic [6:0]       live_count,
	output logic [31:0]      code_out,
	output logic [31:0]      date_out
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = CNT_W + 6;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  scan_idx_q, scan_idx_d;
	logic              chk_vld_q, chk_vld_d;
	logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
	logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
	logic [1:0]        mode_q, mode_d;
	logic [63:0]       key_q, key_d;
	logic [2:0]        status_q, status_d;
	logic [5:0]        fidx_q, fidx_d;
	logic [6:0]        live_q, live_d;
	logic [63:0]       okey_q, okey_d;

	logic [63:0]       mem_q [CAPACITY];
	logic [63:0]       rd_data_q;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [63:0]       wr_data;

	logic              hit;
	logic              more;
	logic              in_range;
	logic [CNT_W-1:0]  count_m1;
	logic [CNT_W-1:0]  count_p1;

	assign hit      = chk_vld_q && (rd_data_q == key_q);
	assign more     = scan_idx_q < count_q;
	assign in_range = CMP_W'(read_index) < CMP_W'(count_q);
	assign count_m1 = count_q - 1'b1;
	assign count_p1 = count_q + 1'b1;

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		scan_idx_d = scan_idx_q;
		chk_vld_d  = chk_vld_q;
		chk_idx_d  = chk_idx_q;
		hit_idx_d  = hit_idx_q;
		mode_d     = mode_q;
		key_d      = key_q;
		status_d   = status_q;
		fidx_d     = fidx_q;
		live_d     = live_q;
		okey_d     = okey_q;
		rd_addr    = scan_idx_q[IDX_W-1:0];
		wr_en      = 1'b0;
		wr_addr    = count_q[IDX_W-1:0];
		wr_data    = key_q;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mode_d     = mode;
					key_d      = {product_code, expiry_date};
					scan_idx_d = '0;
					chk_vld_d  = 1'b0;
					live_d     = 7'(count_q);
					case (mode)
						MODE_ADD: begin
							if (count_q >= CNT_W'(CAPACITY)) begin
								status_d = ST_FULL;
								fidx_d   = '0;
								okey_d   = '0;
								state_d  = S_DONE;
							end else begin
								state_d = S_SCAN;
							end
						end
						MODE_READ: begin
							rd_addr = IDX_W'(read_index);
							if (in_range) begin
								fidx_d  = read_index;
								state_d = S_RDWAIT;
							end else begin
								status_d = ST_RANGE_ERR;
								fidx_d   = '0;
								okey_d   = '0;
								state_d  = S_DONE;
							end
						end
						default: begin
							state_d = S_SCAN;
						end
					endcase
				end
			end

			S_SCAN: begin
				if (hit) begin
					fidx_d = 6'(chk_idx_q);
					okey_d = key_q;
					case (mode_q)
						MODE_ADD: begin
							status_d = ST_DUPLICATE;
							state_d  = S_DONE;
						end
						MODE_REMOVE: begin
							// Fetch the last live entry to fill the freed slot.
							rd_addr   = count_m1[IDX_W-1:0];
							hit_idx_d = chk_idx_q;
							state_d   = S_MOVE;
						end
						default: begin
							status_d = ST_FOUND;
							state_d  = S_DONE;
						end
					endcase
				end else if (more) begin
					rd_addr    = scan_idx_q[IDX_W-1:0];
					chk_vld_d  = 1'b1;
					chk_idx_d  = scan_idx_q[IDX_W-1:0];
					scan_idx_d = scan_idx_q + 1'b1;
				end else if (chk_vld_q) begin
					// The last entry read did not match; nothing is left to issue.
					chk_vld_d = 1'b0;
				end else begin
					if (mode_q == MODE_ADD) begin
						wr_en    = 1'b1;
						wr_addr  = count_q[IDX_W-1:0];
						wr_data  = key_q;
						count_d  = count_p1;
						status_d = ST_ADDED;
						fidx_d   = 6'(count_q);
						live_d   = 7'(count_p1);
						okey_d   = key_q;
					end else begin
						status_d = ST_NOT_FOUND;
						fidx_d   = '0;
						okey_d   = '0;
					end
					state_d = S_DONE;
				end
			end

			S_RDWAIT: begin
				status_d = ST_READ_OK;
				okey_d   = rd_data_q;
				state_d  = S_DONE;
			end

			S_MOVE: begin
				wr_en    = 1'b1;
				wr_addr  = hit_idx_q;
				wr_data  = rd_data_q;
				count_d  = count_m1;
				status_d = ST_FOUND;
				live_d   = 7'(count_m1);
				state_d  = S_DONE;
			end

			S_DONE: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			chk_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			scan_idx_q <= scan_idx_d;
			chk_vld_q  <= chk_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_q <= chk_idx_d;
		hit_idx_q <= hit_idx_d;
		mode_q    <= mode_d;
		key_q     <= key_d;
		status_q  <= status_d;
		fidx_q    <= fidx_d;
		live_q    <= live_d;
		okey_q    <= okey_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = (state_q == S_DONE);
	assign status      = status_q;
	assign found_index = fidx_q;
	assign live_count  = live_q;
	assign code_out    = okey_q[63:32];
	assign date_out    = okey_q[31:0];

endmodule

`default_nettype wire
